// ===== sv/arp_pkg.sv =====
// Package: ARP cache word types and fixed header constants.
package arp_pkg;

	typedef struct packed {
		logic        action;
		logic [15:0] opcode;
		logic [31:0] sender_ip;
		logic [47:0] sender_mac;
		logic [31:0] target_ip;
		logic [15:0] hw_type;
		logic [15:0] proto_type;
		logic [7:0]  hw_len;
		logic [7:0]  proto_len;
		logic [31:0] lookup_ip;
	} arp_item_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [47:0] dest_mac;
		logic [15:0] out_opcode;
		logic [15:0] out_hw_type;
		logic [15:0] out_proto_type;
		logic [7:0]  out_hw_len;
		logic [7:0]  out_proto_len;
		logic [47:0] out_sender_mac;
		logic [31:0] out_sender_ip;
		logic [47:0] out_target_mac;
		logic [31:0] out_target_ip;
		logic [47:0] resolved_mac;
	} arp_result_t;

	localparam logic        ACT_PACKET  = 1'b0;
	localparam logic        ACT_RESOLVE = 1'b1;

	localparam logic [1:0]  KIND_REPLY = 2'd0;
	localparam logic [1:0]  KIND_HIT   = 2'd1;
	localparam logic [1:0]  KIND_MISS  = 2'd2;

	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY   = 16'd2;

	localparam logic [15:0] HTYPE_ETH   = 16'd1;
	localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
	localparam logic [7:0]  HLEN_ETH    = 8'd6;
	localparam logic [7:0]  PLEN_IPV4   = 8'd4;
	localparam logic [47:0] MAC_BCAST   = {6{8'hFF}};

	localparam logic        REG_LOCAL_IP  = 1'b0;
	localparam logic        REG_LOCAL_MAC = 1'b1;

endpackage

// ===== sv/arp_cache_responder.sv =====
// Top level: ARP cache with request responder and address resolver.
//
// Pulse start while busy is low to hand in one word; busy stays high until the
// item is finished. The cache is scanned one entry per cycle through a single
// compare unit reading a registered memory port; the scan stops at the first
// match or after the last entry, so at most CACHE_ENTRIES entries are compared.
// Results appear on result marked by done, which is high for a single cycle, and cannot be
// held off. A packet that is not a request for local_ip yields no result.
// Cache entries are cleared at reset through per-entry valid bits, with no sweep.
module arp_cache_responder #(
	parameter int CACHE_ENTRIES = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  arp_pkg::arp_item_t  item,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [47:0]         cfg_wdata,
	output logic                done,
	output arp_pkg::arp_result_t result
);
	import arp_pkg::*;

	localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST = IW'(CACHE_ENTRIES - 1);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_PRIME = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t state_q;

	logic [31:0] local_ip_q;
	logic [47:0] local_mac_q;

	arp_item_t item_q;

	logic [31:0] ip_mem  [CACHE_ENTRIES];
	logic [47:0] mac_mem [CACHE_ENTRIES];
	logic [CACHE_ENTRIES-1:0] valid_q;

	logic [IW-1:0] addr_q;
	logic [IW-1:0] cmp_idx_q;
	logic [31:0]   rd_ip_q;
	logic [47:0]   rd_mac_q;
	logic          rd_vld_q;

	logic          hit_q;
	logic [IW-1:0] hit_idx_q;
	logic [47:0]   hit_mac_q;

	logic          done_q;
	arp_result_t   result_q;
	arp_result_t   result_d;

	logic [31:0] e_ip;
	logic [47:0] e_mac;
	logic [31:0] key_ip;
	logic        match;
	logic        reply_due;
	logic        write_en;

	assign e_ip   = rd_vld_q ? rd_ip_q : 32'd0;
	assign e_mac  = rd_vld_q ? rd_mac_q : 48'd0;
	assign key_ip = (item_q.action == ACT_RESOLVE) ? item_q.lookup_ip : item_q.sender_ip;
	assign match  = (e_ip == key_ip) || ((item_q.action == ACT_PACKET) && (e_ip == 32'd0));

	assign reply_due = (item_q.action == ACT_PACKET) && (item_q.opcode == OP_REQUEST) &&
		(item_q.target_ip == local_ip_q);
	assign write_en  = (state_q == S_DONE) && (item_q.action == ACT_PACKET) && hit_q;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q  <= '0;
			local_mac_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL_IP:  local_ip_q  <= cfg_wdata[31:0];
				REG_LOCAL_MAC: local_mac_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (write_en) begin
			ip_mem[hit_idx_q]  <= item_q.sender_ip;
			mac_mem[hit_idx_q] <= item_q.sender_mac;
		end
		rd_ip_q   <= ip_mem[addr_q];
		rd_mac_q  <= mac_mem[addr_q];
		rd_vld_q  <= valid_q[addr_q];
		cmp_idx_q <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (write_en) begin
			valid_q[hit_idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			addr_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					addr_q <= '0;
					if (start) begin
						state_q <= S_PRIME;
					end
				end
				S_PRIME: begin
					if (addr_q != LAST) begin
						addr_q <= addr_q + 1'b1;
					end
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (match || (cmp_idx_q == LAST)) begin
						state_q <= S_DONE;
					end else if (addr_q != LAST) begin
						addr_q <= addr_q + 1'b1;
					end
				end
				S_DONE: begin
					done_q  <= (item_q.action == ACT_RESOLVE) || reply_due;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		result_d = '0;
		if (item_q.action == ACT_PACKET) begin
			result_d.result_kind    = KIND_REPLY;
			result_d.dest_mac       = item_q.sender_mac;
			result_d.out_opcode     = OP_REPLY;
			result_d.out_hw_type    = item_q.hw_type;
			result_d.out_proto_type = item_q.proto_type;
			result_d.out_hw_len     = item_q.hw_len;
			result_d.out_proto_len  = item_q.proto_len;
			result_d.out_sender_mac = local_mac_q;
			result_d.out_sender_ip  = local_ip_q;
			result_d.out_target_mac = item_q.sender_mac;
			result_d.out_target_ip  = item_q.sender_ip;
		end else if (hit_q) begin
			result_d.result_kind  = KIND_HIT;
			result_d.resolved_mac = hit_mac_q;
		end else begin
			result_d.result_kind    = KIND_MISS;
			result_d.dest_mac       = MAC_BCAST;
			result_d.out_opcode     = OP_REQUEST;
			result_d.out_hw_type    = HTYPE_ETH;
			result_d.out_proto_type = PTYPE_IPV4;
			result_d.out_hw_len     = HLEN_ETH;
			result_d.out_proto_len  = PLEN_IPV4;
			result_d.out_sender_mac = local_mac_q;
			result_d.out_sender_ip  = local_ip_q;
			result_d.out_target_ip  = item_q.lookup_ip;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			item_q <= item;
			hit_q  <= 1'b0;
		end
		if (state_q == S_SCAN && match) begin
			hit_q     <= 1'b1;
			hit_idx_q <= cmp_idx_q;
			hit_mac_q <= e_mac;
		end
		if (state_q == S_DONE) begin
			result_q <= result_d;
		end
	end

endmodule
